FILE: hw/rtl/bcrte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcrte_pkg;

	// Register masks of the clock chip.
	localparam logic [7:0] SecMask     = 8'h7f;
	localparam logic [7:0] MinMask     = 8'h7f;
	localparam logic [7:0] Hour12Mask  = 8'h1f;
	localparam logic [7:0] Hour24Mask  = 8'h3f;
	localparam logic [7:0] DateMask    = 8'h3f;
	localparam logic [7:0] MonthMask   = 8'h1f;
	localparam int unsigned ModeBit    = 6;   // hour_reg: 12-hour mode
	localparam int unsigned PmBit      = 5;   // hour_reg: PM in 12-hour mode
	localparam int unsigned StartBit   = 7;   // sec_reg: oscillator start
	localparam int unsigned RunBit     = 5;   // wday_reg: oscillator running

	localparam logic [15:0] DaysTo2000  = 16'd10957;
	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [11:0] SecsPerHour = 12'd3600;

	// Binary fields after the digit decode.
	typedef struct packed {
		logic       ok;
		logic       run;
		logic [6:0] sec;
		logic [6:0] min;
		logic [5:0] hour;
		logic [5:0] day;
		logic [4:0] month;
		logic [6:0] year;
	} dec_t;

	// Day count and second of day after the calendar check.
	typedef struct packed {
		logic        ok;
		logic        run;
		logic [15:0] days;
		logic [16:0] sod;
	} cal_t;

	function automatic logic bcd_ok(input logic [7:0] v);
		bcd_ok = (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
	endfunction

	function automatic logic [6:0] bcd_val(input logic [7:0] v);
		bcd_val = {3'b000, v[7:4]} * 7'd10 + {3'b000, v[3:0]};
	endfunction

	function automatic logic [4:0] month_len(input logic [4:0] m);
		unique case (m)
			5'd2:                        month_len = 5'd28;
			5'd4, 5'd6, 5'd9, 5'd11:     month_len = 5'd30;
			5'd1, 5'd3, 5'd5, 5'd7,
			5'd8, 5'd10, 5'd12:          month_len = 5'd31;
			default:                     month_len = 5'd0;
		endcase
	endfunction

	function automatic logic [8:0] days_before(input logic [4:0] m);
		unique case (m)
			5'd1:    days_before = 9'd0;
			5'd2:    days_before = 9'd31;
			5'd3:    days_before = 9'd59;
			5'd4:    days_before = 9'd90;
			5'd5:    days_before = 9'd120;
			5'd6:    days_before = 9'd151;
			5'd7:    days_before = 9'd181;
			5'd8:    days_before = 9'd212;
			5'd9:    days_before = 9'd243;
			5'd10:   days_before = 9'd273;
			5'd11:   days_before = 9'd304;
			5'd12:   days_before = 9'd334;
			default: days_before = 9'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bcrte_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module bcrte_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [55:0]     in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcrte_pkg::dec_t      out_dec
);

	logic            valid_s1;
	bcrte_pkg::dec_t dec_s1;
	bcrte_pkg::dec_t dec_d;

	logic [7:0] sr, mr, hr, wr, dr, mo, yr;
	logic [7:0] hour_raw;
	logic [6:0] hour_bin;
	logic       twelve;
	logic       digits_ok;

	assign sr = in_data[7:0];
	assign mr = in_data[15:8];
	assign hr = in_data[23:16];
	assign wr = in_data[31:24];
	assign dr = in_data[39:32];
	assign mo = in_data[47:40];
	assign yr = in_data[55:48];

	always_comb begin
		twelve   = hr[bcrte_pkg::ModeBit];
		hour_raw = hr & (twelve ? bcrte_pkg::Hour12Mask : bcrte_pkg::Hour24Mask);
		hour_bin = bcrte_pkg::bcd_val(hour_raw);
		digits_ok = bcrte_pkg::bcd_ok(sr & bcrte_pkg::SecMask)
			&& bcrte_pkg::bcd_ok(mr & bcrte_pkg::MinMask)
			&& bcrte_pkg::bcd_ok(hour_raw)
			&& bcrte_pkg::bcd_ok(dr & bcrte_pkg::DateMask)
			&& bcrte_pkg::bcd_ok(mo & bcrte_pkg::MonthMask)
			&& bcrte_pkg::bcd_ok(yr)
			&& (wr[2:0] != 3'd0);

		dec_d.run   = sr[bcrte_pkg::StartBit] & wr[bcrte_pkg::RunBit];
		dec_d.sec   = bcrte_pkg::bcd_val(sr & bcrte_pkg::SecMask);
		dec_d.min   = bcrte_pkg::bcd_val(mr & bcrte_pkg::MinMask);
		dec_d.day   = 6'(bcrte_pkg::bcd_val(dr & bcrte_pkg::DateMask));
		dec_d.month = 5'(bcrte_pkg::bcd_val(mo & bcrte_pkg::MonthMask));
		dec_d.year  = bcrte_pkg::bcd_val(yr);
		dec_d.ok    = digits_ok;
		dec_d.hour  = 6'(hour_bin);
		if (twelve) begin
			// 12 AM is hour 0, 12 PM stays 12; anything outside 1..12 is rejected.
			if (hour_bin < 7'd1 || hour_bin > 7'd12) begin
				dec_d.ok = 1'b0;
			end
			dec_d.hour = ((hour_bin == 7'd12) ? 6'd0 : 6'(hour_bin))
				+ (hr[bcrte_pkg::PmBit] ? 6'd12 : 6'd0);
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_dec   = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bcrte_calendar.sv
`timescale 1ns / 1ps
`default_nettype none
module bcrte_calendar (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bcrte_pkg::dec_t in_dec,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcrte_pkg::cal_t      out_cal
);

	logic            valid_s2;
	bcrte_pkg::cal_t cal_s2;
	bcrte_pkg::cal_t cal_d;

	logic       leap;
	logic [5:0] dim;
	logic [7:0] leap_days;

	always_comb begin
		leap      = (in_dec.year[1:0] == 2'd0);
		dim       = {1'b0, bcrte_pkg::month_len(in_dec.month)}
			+ {5'd0, (in_dec.month == 5'd2) && leap};
		leap_days = ({1'b0, in_dec.year} + 8'd3) >> 2;

		cal_d.run = in_dec.run;
		cal_d.ok  = in_dec.ok
			&& (in_dec.month >= 5'd1) && (in_dec.month <= 5'd12)
			&& (in_dec.day >= 6'd1) && (in_dec.day <= dim)
			&& (in_dec.hour <= 6'd23)
			&& (in_dec.min <= 7'd59) && (in_dec.sec <= 7'd59);

		cal_d.days = bcrte_pkg::DaysTo2000
			+ {9'd0, in_dec.year} * 16'd365
			+ {8'd0, leap_days}
			+ {7'd0, bcrte_pkg::days_before(in_dec.month)}
			+ {15'd0, (in_dec.month > 5'd2) && leap}
			+ {10'd0, in_dec.day} - 16'd1;

		cal_d.sod = {11'd0, in_dec.hour} * {5'd0, bcrte_pkg::SecsPerHour}
			+ {10'd0, in_dec.min} * 17'd60
			+ {10'd0, in_dec.sec};
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_cal   = cal_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cal_s2 <= cal_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bcrte_epoch.sv
`timescale 1ns / 1ps
`default_nettype none
module bcrte_epoch (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bcrte_pkg::cal_t in_cal,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 out_time_valid,
	output logic                 out_running,
	output logic [31:0]          out_epoch
);

	logic        valid_s3;
	logic        ok_s3;
	logic        run_s3;
	logic [31:0] epoch_s3;
	logic [31:0] product;
	logic [31:0] epoch_d;

	always_comb begin
		product = {16'd0, in_cal.days} * {15'd0, bcrte_pkg::SecsPerDay};
		epoch_d = in_cal.ok ? (product + {15'd0, in_cal.sod}) : 32'd0;
	end

	assign in_ready       = !valid_s3 || out_ready;
	assign out_valid      = valid_s3;
	assign out_time_valid = ok_s3;
	assign out_running    = run_s3;
	assign out_epoch      = epoch_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ok_s3    <= in_cal.ok;
			run_s3   <= in_cal.ok & in_cal.run;
			epoch_s3 <= epoch_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bcd_clock_registers_to_epoch.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata[55:0]: sec, min, hour, wday, date, month, year registers
// m_axis    out        tdata[31:0]: epoch seconds; tuser[1:0]: time valid, clock running
//
// An input transaction accepted at one edge is registered in stage one, then in stage
// two and stage three, whose register drives the output; one transaction is accepted
// every cycle while the output is ready. Stage one decodes the BCD digits and the 12-hour
// mode, stage two checks the calendar and builds the day count and second of day, stage
// three holds the day-to-seconds multiplier. Reset clears only the stage valid bits.
// A stalled output freezes the full stage chain behind it; each empty stage still takes
// a new transaction.
module bcd_clock_registers_to_epoch (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// sec_reg, min_reg, hour_reg, wday_reg, date_reg, month_reg, year_reg
	// (8 bits each, from the lowest bit up)
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// epoch_seconds
	output logic [31:0]      m_tdata,
	// time_valid (bit 0), clock_running (bit 1)
	output logic [1:0]       m_tuser
);

	logic            dec_valid, dec_ready;
	bcrte_pkg::dec_t dec;
	logic            cal_valid, cal_ready;
	bcrte_pkg::cal_t cal;
	logic            time_valid, clock_running;

	// Digit decode, weekday check and 12-to-24-hour mapping.
	bcrte_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_dec   (dec)
	);

	// Range checks against month length; days since 1970 and second of day.
	bcrte_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_dec    (dec),
		.out_valid (cal_valid),
		.out_ready (cal_ready),
		.out_cal   (cal)
	);

	// Final multiply by seconds per day; the result is forced to zero when invalid.
	bcrte_epoch u_epoch (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (cal_valid),
		.in_ready       (cal_ready),
		.in_cal         (cal),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_time_valid (time_valid),
		.out_running    (clock_running),
		.out_epoch      (m_tdata)
	);

	assign m_tuser = {clock_running, time_valid};

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;

	// One register snapshot of the clock chip. The first declared field lands in the
	// highest bits, so the packed struct matches s_tdata with the seconds register
	// in the lowest byte.
	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] date;
		logic [7:0] wday;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} snapshot_t;

	// The decoded time as the block reports it.
	typedef struct packed {
		logic        valid;
		logic        running;
		logic [31:0] epoch;
	} reading_t;

	// Ways in which the random stimulus spoils an otherwise legal snapshot.
	typedef enum int {
		FLAW_BYTE,
		FLAW_ALL,
		FLAW_DIGIT,
		FLAW_DAY,
		FLAW_MONTH,
		FLAW_HOUR,
		FLAW_MINSEC,
		FLAW_WEEKDAY
	} flaw_t;

	// Receiver behaviors; each lasts for a random stretch of cycles.
	typedef enum int {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY,
		READY_ALTERNATE
	} ready_mode_t;

	localparam logic [7:0] WeekdayMask = 8'h07;
	localparam int unsigned RandomItems = 1100;
	localparam int unsigned IdleLimit = 3000;
	localparam int unsigned DrainCycles = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	snapshot_t   pending_snapshots[$];
	reading_t    expected_readings[$];
	snapshot_t   held_snapshot = '0;
	logic        holding = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned accepted_items = 0;
	int unsigned total_items = 0;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int unsigned mode_left = 0;

	bcd_clock_registers_to_epoch dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned month_days(int unsigned mon, int unsigned yr);
		case (mon)
			2: return (yr % 4 == 0) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic logic [7:0] to_bcd(int unsigned v);
		return 8'((v / 10) * 16 + v % 10);
	endfunction

	function automatic logic digits_ok(logic [7:0] v);
		return (v[3:0] < 4'd10) && (v[7:4] < 4'd10);
	endfunction

	function automatic int unsigned from_bcd(logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	// Predicts what the block reports for one snapshot. Control bits are masked off
	// first, then every digit, the weekday, the 12-hour mapping and the calendar are
	// checked in turn; only a snapshot that passes everything gets a nonzero epoch.
	function automatic reading_t convert_snapshot(snapshot_t sn);
		logic        twelve;
		logic        ok;
		logic [7:0]  hour_bits;
		int unsigned se, mi, hr, dy, mon, yr, day_count, m_idx;
		reading_t    r;
		twelve = sn.hour[bcrte_pkg::ModeBit];
		hour_bits = sn.hour & (twelve ? bcrte_pkg::Hour12Mask : bcrte_pkg::Hour24Mask);
		ok = digits_ok(sn.second & bcrte_pkg::SecMask)
			&& digits_ok(sn.minute & bcrte_pkg::MinMask)
			&& digits_ok(hour_bits) && digits_ok(sn.date & bcrte_pkg::DateMask)
			&& digits_ok(sn.month & bcrte_pkg::MonthMask) && digits_ok(sn.year)
			&& ((sn.wday & WeekdayMask) != 8'h00);
		se = from_bcd(sn.second & bcrte_pkg::SecMask);
		mi = from_bcd(sn.minute & bcrte_pkg::MinMask);
		hr = from_bcd(hour_bits);
		dy = from_bcd(sn.date & bcrte_pkg::DateMask);
		mon = from_bcd(sn.month & bcrte_pkg::MonthMask);
		yr = from_bcd(sn.year);
		// In 12-hour mode twelve o'clock folds to zero before the PM offset, so
		// 12 AM is midnight and 12 PM is noon.
		if (ok && twelve) begin
			if (hr < 1 || hr > 12)
				ok = 1'b0;
			else
				hr = hr % 12 + (sn.hour[bcrte_pkg::PmBit] ? 12 : 0);
		end
		if (ok && (mon < 1 || mon > 12))
			ok = 1'b0;
		if (ok && (dy < 1 || dy > month_days(mon, yr) || hr > 23 || mi > 59 || se > 59))
			ok = 1'b0;
		day_count = bcrte_pkg::DaysTo2000 + yr * 365 + (yr + 3) / 4 + dy - 1;
		for (m_idx = 1; m_idx < mon && m_idx <= 12; m_idx++)
			day_count += month_days(m_idx, yr);
		r.valid = ok;
		r.running = ok && sn.second[bcrte_pkg::StartBit] && sn.wday[bcrte_pkg::RunBit];
		r.epoch = ok ? 32'(day_count * bcrte_pkg::SecsPerDay
			+ hr * bcrte_pkg::SecsPerHour + mi * 60 + se) : 32'd0;
		return r;
	endfunction

	// Builds a legal snapshot. The noise word fills the bits that the block must
	// ignore: minute bit 7, hour bit 7, weekday bits 7..6 and 4..3, date bits 7..6
	// and month bits 7..5.
	function automatic snapshot_t make_snapshot(int unsigned yr, int unsigned mon,
			int unsigned dy, int unsigned hr, int unsigned mi, int unsigned se,
			int unsigned twelve, int unsigned start, int unsigned run, int unsigned wd,
			logic [31:0] noise);
		snapshot_t sn;
		int unsigned h12;
		h12 = (hr % 12 == 0) ? 12 : hr % 12;
		sn.second = to_bcd(se);
		sn.second[bcrte_pkg::StartBit] = 1'(start);
		sn.minute = to_bcd(mi);
		sn.minute[7] = noise[0];
		if (twelve != 0) begin
			sn.hour = to_bcd(h12);
			sn.hour[bcrte_pkg::ModeBit] = 1'b1;
			sn.hour[bcrte_pkg::PmBit] = (hr >= 12);
		end else begin
			sn.hour = to_bcd(hr);
		end
		sn.hour[7] = noise[1];
		sn.wday = 8'(wd);
		sn.wday[bcrte_pkg::RunBit] = 1'(run);
		sn.wday[7:6] = noise[3:2];
		sn.wday[4:3] = noise[5:4];
		sn.date = to_bcd(dy);
		sn.date[7:6] = noise[7:6];
		sn.month = to_bcd(mon);
		sn.month[7:5] = noise[10:8];
		sn.year = to_bcd(yr);
		return sn;
	endfunction

	// Returns a random legal snapshot with random control and unused bits.
	function automatic snapshot_t random_legal_snapshot();
		int unsigned yr, mon;
		yr = $urandom_range(0, 99);
		mon = $urandom_range(1, 12);
		return make_snapshot(yr, mon, $urandom_range(1, month_days(mon, yr)),
			$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
			$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(1, 7), $urandom);
	endfunction

	// Queues a copy of a base snapshot with one register byte replaced.
	task automatic queue_with_byte(snapshot_t base, int unsigned idx, logic [7:0] v);
		logic [55:0] raw;
		raw = base;
		raw[idx * 8 +: 8] = v;
		pending_snapshots.push_back(snapshot_t'(raw));
	endtask

	// Stimulus: a directed set first, then random snapshots that are mostly legal
	// times with random content, the rest spoiled in one targeted way or pure noise.
	initial begin
		snapshot_t   base;
		snapshot_t   sn;
		logic [55:0] raw;
		flaw_t       flaw;
		int unsigned n, idx, mon, yr;

		// Both ends of the supported range, and the top end in 12-hour mode.
		pending_snapshots.push_back(make_snapshot(0, 1, 1, 0, 0, 0, 0, 0, 0, 1, '0));
		pending_snapshots.push_back(make_snapshot(99, 12, 31, 23, 59, 59, 0, 1, 1, 7, '0));
		pending_snapshots.push_back(make_snapshot(99, 12, 31, 23, 59, 59, 1, 1, 1, 7, '1));
		// Leap days, twelve o'clock noon and midnight, and a day past a month's end.
		pending_snapshots.push_back(make_snapshot(24, 2, 29, 12, 0, 0, 1, 1, 0, 3, '0));
		pending_snapshots.push_back(make_snapshot(0, 2, 29, 0, 0, 0, 1, 0, 1, 2, '0));
		pending_snapshots.push_back(make_snapshot(23, 2, 29, 8, 15, 45, 0, 1, 1, 4, '0));
		pending_snapshots.push_back(make_snapshot(1, 2, 28, 21, 1, 2, 1, 1, 1, 5, '0));
		pending_snapshots.push_back(make_snapshot(24, 3, 1, 13, 30, 30, 1, 1, 1, 6, '0));
		pending_snapshots.push_back(make_snapshot(50, 4, 31, 6, 7, 8, 0, 1, 1, 1, '0));
		pending_snapshots.push_back(make_snapshot(50, 4, 30, 6, 7, 8, 0, 1, 1, 1, '0));
		pending_snapshots.push_back(make_snapshot(70, 6, 15, 17, 20, 40, 0, 1, 0, 2, '1));
		pending_snapshots.push_back(make_snapshot(70, 6, 15, 17, 20, 40, 1, 0, 1, 2, '1));

		// Single bad registers on top of a legal 24-hour base time.
		base = make_snapshot(37, 8, 19, 9, 41, 27, 0, 1, 1, 3, '0);
		queue_with_byte(base, 0, 8'h8a);   // bad seconds digit
		queue_with_byte(base, 1, 8'h3f);   // bad minutes digit
		queue_with_byte(base, 2, 8'h1b);   // bad hour digit
		queue_with_byte(base, 4, 8'h0e);   // bad day digit
		queue_with_byte(base, 5, 8'h0c);   // bad month digit
		queue_with_byte(base, 6, 8'ha5);   // bad year digit
		queue_with_byte(base, 3, 8'hf8);   // zero weekday, other bits all set
		queue_with_byte(base, 2, 8'h40);   // 12-hour mode, hour zero
		queue_with_byte(base, 2, 8'h73);   // 12-hour mode, hour thirteen PM
		queue_with_byte(base, 2, 8'h24);   // 24-hour mode, hour 24
		queue_with_byte(base, 1, 8'h60);   // minute 60
		queue_with_byte(base, 0, 8'he0);   // second 60 with the start bit
		queue_with_byte(base, 5, 8'h00);   // month zero
		queue_with_byte(base, 5, 8'h13);   // month thirteen
		queue_with_byte(base, 4, 8'h00);   // day zero

		for (n = 0; n < RandomItems; n++) begin
			sn = random_legal_snapshot();
			if ($urandom_range(0, 99) < 35) begin
				flaw = flaw_t'($urandom_range(FLAW_BYTE, FLAW_WEEKDAY));
				raw = sn;
				idx = $urandom_range(0, 6);
				mon = from_bcd(sn.month & bcrte_pkg::MonthMask);
				yr = from_bcd(sn.year);
				case (flaw)
					FLAW_BYTE: begin
						raw[idx * 8 +: 8] = 8'($urandom);
					end
					FLAW_ALL: begin
						raw = 56'({$urandom, $urandom});
					end
					FLAW_DIGIT: begin
						raw[idx * 8 +: 4] = 4'($urandom_range(10, 15));
					end
					FLAW_DAY: begin
						raw[39:32] = ($urandom_range(0, 1) == 1) ? to_bcd(month_days(mon, yr) + 1)
							: 8'h00;
					end
					FLAW_MONTH: begin
						raw[47:40] = ($urandom_range(0, 1) == 1) ? to_bcd($urandom_range(13, 19))
							: 8'h00;
					end
					FLAW_HOUR: begin
						if ($urandom_range(0, 1) == 1) begin
							raw[23:16] = to_bcd($urandom_range(24, 39));
						end else begin
							raw[20:16] = ($urandom_range(0, 1) == 1) ? 5'h00
								: 5'(to_bcd($urandom_range(13, 19)));
							raw[16 + bcrte_pkg::ModeBit] = 1'b1;
						end
					end
					FLAW_MINSEC: begin
						raw[idx[0] * 8 +: 7] = 7'(to_bcd($urandom_range(60, 79)));
					end
					FLAW_WEEKDAY: begin
						raw[26:24] = 3'b000;
					end
					default: begin
					end
				endcase
				sn = snapshot_t'(raw);
			end
			pending_snapshots.push_back(sn);
		end
		total_items = pending_snapshots.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every snapshot to be taken and every reading to come back, then
		// let the clock run on so that any stray result still shows.
		while (accepted_items < total_items || expected_readings.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Driver: sends snapshots in bursts of random length separated by random gaps.
	// A snapshot stays on the bus until its transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(convert_snapshot(held_snapshot));
				accepted_items++;
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_snapshots.size() > 0) begin
					held_snapshot = pending_snapshots.pop_front();
					holding = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			s_tvalid <= holding;
			s_tdata <= held_snapshot;
		end
	end

	// Monitor: checks each reading against the oldest prediction and drives the
	// receiver's stall pattern, which switches between a few behaviors.
	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		logic     ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.valid = m_tuser[0];
				got.running = m_tuser[1];
				got.epoch = m_tdata;
				if (expected_readings.size() == 0) begin
					errors++;
					$display("%0t: reading with no snapshot pending: valid %0b running %0b epoch %0d",
						$time, got.valid, got.running, got.epoch);
				end else begin
					want = expected_readings.pop_front();
					if (got.valid !== want.valid) begin
						errors++;
						$display("%0t: time_valid expected %0b actual %0b",
							$time, want.valid, got.valid);
					end
					if (got.running !== want.running) begin
						errors++;
						$display("%0t: clock_running expected %0b actual %0b",
							$time, want.running, got.running);
					end
					if (got.epoch !== want.epoch) begin
						errors++;
						$display("%0t: epoch_seconds expected %0d actual %0d",
							$time, want.epoch, got.epoch);
					end
				end
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(READY_ALWAYS, READY_ALTERNATE));
				mode_left = $urandom_range(16, 200);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				READY_ALWAYS: ready_next = 1'b1;
				READY_MOSTLY: ready_next = ($urandom_range(0, 7) != 0);
				READY_RARELY: ready_next = ($urandom_range(0, 3) == 0);
				default: ready_next = !m_tready;
			endcase
			m_tready <= ready_next;
		end
	end

	// Watchdog: a long stretch with no transaction on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

FILE: filelist.f
hw/rtl/bcrte_pkg.sv
hw/rtl/bcrte_decode.sv
hw/rtl/bcrte_calendar.sv
hw/rtl/bcrte_epoch.sv
hw/rtl/bcd_clock_registers_to_epoch.sv
test/tb.sv
